FILE: hw/rtl/ucuf_pkg.sv
// Package for the UTF-8 Cyrillic upper-case folder.
// Holds the byte constants, the channel payload types and the queue sizing.
// It has no dependencies.
package ucuf_pkg;

  // Byte codes that the folding rules test for or produce.
  localparam logic [7:0] LEAD_D0   = 8'hD0;
  localparam logic [7:0] LEAD_D1   = 8'hD1;
  localparam logic [7:0] LOW_B0    = 8'hB0;
  localparam logic [7:0] HIGH_BF   = 8'hBF;
  localparam logic [7:0] LOW_80    = 8'h80;
  localparam logic [7:0] HIGH_8F   = 8'h8F;
  localparam logic [7:0] SMALL_YO  = 8'h91;
  localparam logic [7:0] CAP_YO    = 8'h81;
  localparam logic [7:0] CASE_GAP  = 8'h20;
  localparam logic [7:0] ASCII_SP  = 8'h20;
  localparam logic [7:0] ASCII_CR  = 8'h0D;
  localparam logic [7:0] ASCII_LF  = 8'h0A;
  localparam logic [7:0] ASCII_TAB = 8'h09;
  localparam logic [7:0] ASCII_LC_A = 8'h61;
  localparam logic [7:0] ASCII_LC_Z = 8'h7A;

  // Masks and patterns of the other multibyte lead bytes.
  localparam logic [7:0] MASK_2B = 8'hE0;
  localparam logic [7:0] PAT_2B  = 8'hC0;
  localparam logic [7:0] MASK_3B = 8'hF0;
  localparam logic [7:0] PAT_3B  = 8'hE0;
  localparam logic [7:0] MASK_4B = 8'hF8;
  localparam logic [7:0] PAT_4B  = 8'hF0;

  // Queue between the classifier and the output sequencer.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // One classified item: one or two bytes to emit, and the end-of-string mark.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       last;
  } entry_t;

endpackage

FILE: hw/rtl/utf8_cyrillic_upper_fold.sv
// Top level of the UTF-8 Cyrillic upper-case folder.
// Instantiates ucuf_front, ucuf_queue and ucuf_back; types come from ucuf_pkg.
//
//   Channel  Handshake                  Payload  Moves
//   raw      raw_valid / raw_ready      in_t     one text byte and its end mark
//   folded   folded_valid / folded_ready out_t   one folded byte and its end mark
//
// One raw byte is taken per cycle while the two-entry queue has room; it is
// classified and the multibyte state updates at the accepting edge.
// The first output byte passes a queue slot, then the output register cur;
// with folded_ready high, ordinary text streams at one byte per cycle.
// A held D0/D1 lead yields no transaction; reset clears state, queue and output.
// A stall on the folded side fills the queue and then drops raw_ready.
module utf8_cyrillic_upper_fold (
  input  logic           clk,
  input  logic           rst,
  input  logic           raw_valid,
  output logic           raw_ready,
  input  ucuf_pkg::in_t  raw,
  output logic           folded_valid,
  input  logic           folded_ready,
  output ucuf_pkg::out_t folded
);

  // Classified entries travel from the front end into the queue here.
  logic             push;
  logic             push_ready;
  ucuf_pkg::entry_t push_entry;

  // And from the queue into the output sequencer here.
  logic             pop;
  logic             pop_valid;
  ucuf_pkg::entry_t pop_entry;

  // The front end holds the lead byte and the pass-through count. raw_ready
  // follows the queue alone, even for a byte that yields no output.
  ucuf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw_valid  (raw_valid),
    .raw_ready  (raw_ready),
    .raw        (raw),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (push_ready)
  );

  ucuf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  // The output sequencer loads the next entry in the same cycle its current
  // one finishes, so single-byte entries flow out without a bubble.
  ucuf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (pop_valid),
    .q_entry      (pop_entry),
    .pop          (pop),
    .folded_valid (folded_valid),
    .folded_ready (folded_ready),
    .folded       (folded)
  );

endmodule

FILE: hw/rtl/ucuf_front.sv
// Front end of the folder: accepts raw bytes, tracks the multibyte state
// and turns each byte but a held D0/D1 lead into a queue entry of one or two output bytes.
// Depends on ucuf_pkg.
module ucuf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            raw_valid,
  output logic            raw_ready,
  input  ucuf_pkg::in_t   raw,
  output logic            push,
  output ucuf_pkg::entry_t push_entry,
  input  logic            q_ready
);

  logic       lead_held, lead_held_next;
  logic [7:0] held_lead_byte, held_lead_byte_next;
  logic [1:0] bytes_to_pass, bytes_to_pass_next;

  logic       accept;
  logic       emit;
  logic [7:0] b;
  logic [7:0] lead;
  logic [7:0] second;

  assign raw_ready = q_ready;
  assign accept    = raw_valid && raw_ready;

  always_comb begin
    if (raw.in_byte == ucuf_pkg::ASCII_CR || raw.in_byte == ucuf_pkg::ASCII_LF ||
        raw.in_byte == ucuf_pkg::ASCII_TAB) begin
      b = ucuf_pkg::ASCII_SP;
    end else begin
      b = raw.in_byte;
    end
  end

  always_comb begin
    lead   = held_lead_byte;
    second = b;
    if (held_lead_byte == ucuf_pkg::LEAD_D0 && b >= ucuf_pkg::LOW_B0 &&
        b <= ucuf_pkg::HIGH_BF) begin
      second = b - ucuf_pkg::CASE_GAP;
    end else if (held_lead_byte == ucuf_pkg::LEAD_D1 && b >= ucuf_pkg::LOW_80 &&
                 b <= ucuf_pkg::HIGH_8F) begin
      lead   = ucuf_pkg::LEAD_D0;
      second = b + ucuf_pkg::CASE_GAP;
    end else if (held_lead_byte == ucuf_pkg::LEAD_D1 && b == ucuf_pkg::SMALL_YO) begin
      lead   = ucuf_pkg::LEAD_D0;
      second = ucuf_pkg::CAP_YO;
    end
  end

  always_comb begin
    emit                = 1'b1;
    push_entry.two      = 1'b0;
    push_entry.byte0    = b;
    push_entry.byte1    = second;
    push_entry.last     = raw.in_last;
    lead_held_next      = lead_held;
    held_lead_byte_next = held_lead_byte;
    bytes_to_pass_next  = bytes_to_pass;
    if (bytes_to_pass != 2'd0) begin
      bytes_to_pass_next = bytes_to_pass - 2'd1;
    end else if (lead_held) begin
      push_entry.two      = 1'b1;
      push_entry.byte0    = lead;
      lead_held_next      = 1'b0;
      held_lead_byte_next = 8'h00;
    end else if (b >= ucuf_pkg::ASCII_LC_A && b <= ucuf_pkg::ASCII_LC_Z) begin
      push_entry.byte0 = b - ucuf_pkg::CASE_GAP;
    end else if (b == ucuf_pkg::LEAD_D0 || b == ucuf_pkg::LEAD_D1) begin
      if (!raw.in_last) begin
        emit                = 1'b0;
        lead_held_next      = 1'b1;
        held_lead_byte_next = b;
      end
    end else if ((b & ucuf_pkg::MASK_2B) == ucuf_pkg::PAT_2B) begin
      bytes_to_pass_next = 2'd1;
    end else if ((b & ucuf_pkg::MASK_3B) == ucuf_pkg::PAT_3B) begin
      bytes_to_pass_next = 2'd2;
    end else if ((b & ucuf_pkg::MASK_4B) == ucuf_pkg::PAT_4B) begin
      bytes_to_pass_next = 2'd3;
    end
    if (raw.in_last) begin
      lead_held_next      = 1'b0;
      held_lead_byte_next = 8'h00;
      bytes_to_pass_next  = 2'd0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held      <= 1'b0;
      held_lead_byte <= 8'h00;
      bytes_to_pass  <= 2'd0;
    end else if (accept) begin
      lead_held      <= lead_held_next;
      held_lead_byte <= held_lead_byte_next;
      bytes_to_pass  <= bytes_to_pass_next;
    end
  end

endmodule

FILE: hw/rtl/ucuf_queue.sv
// Short register queue of classified entries between front and back end.
// Depends on ucuf_pkg for the entry type and the depth.
module ucuf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ucuf_pkg::entry_t push_entry,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output ucuf_pkg::entry_t pop_entry
);

  ucuf_pkg::entry_t slots [ucuf_pkg::QDEPTH];

  logic [ucuf_pkg::QPTR_W-1:0] head, tail;
  logic [ucuf_pkg::QCNT_W-1:0] count;
  logic                        do_push, do_pop;

  assign push_ready = count != ucuf_pkg::QCNT_W'(ucuf_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[head];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [ucuf_pkg::QPTR_W-1:0] wrap_inc(
    input logic [ucuf_pkg::QPTR_W-1:0] p
  );
    if (p == ucuf_pkg::QPTR_W'(ucuf_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + ucuf_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= wrap_inc(tail);
      end
      if (do_pop) begin
        head <= wrap_inc(head);
      end
      if (do_push && !do_pop) begin
        count <= count + ucuf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - ucuf_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/ucuf_back.sv
// Back end of the folder: takes queue entries and sends their one or two
// bytes out from a registered output stage. Depends on ucuf_pkg.
module ucuf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  ucuf_pkg::entry_t q_entry,
  output logic             pop,
  output logic             folded_valid,
  input  logic             folded_ready,
  output ucuf_pkg::out_t   folded
);

  ucuf_pkg::entry_t cur;
  logic             cur_valid;
  logic             phase;
  logic             done;
  logic             load;

  // The entry is finished when its final byte is taken.
  assign done = cur_valid && folded_ready && (!cur.two || phase);
  assign load = (!cur_valid || done) && q_valid;
  assign pop  = load;

  assign folded_valid    = cur_valid;
  assign folded.out_byte = phase ? cur.byte1 : cur.byte0;
  assign folded.out_last = cur.last && (!cur.two || phase);

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      cur_valid <= 1'b1;
      phase     <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (cur_valid && folded_ready) begin
      phase <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/ucuf_checker.sv
// Port-level checker for the folder, bound to the top level below.
// Depends on ucuf_pkg for the payload types.
module ucuf_checker (
  input logic           clk,
  input logic           rst,
  input logic           raw_valid,
  input logic           raw_ready,
  input ucuf_pkg::in_t  raw,
  input logic           folded_valid,
  input logic           folded_ready,
  input ucuf_pkg::out_t folded
);

  // Nothing is pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !folded_valid)
    else $error("folded_valid high right after reset");

  // The queue is empty after reset, so a byte can be taken at once.
  a_reset_ready: assert property (@(posedge clk) rst |=> raw_ready)
    else $error("raw_ready low right after reset");

  // A stalled output transaction holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    folded_valid && !folded_ready |=> folded_valid && $stable(folded))
    else $error("stalled folded transaction changed");

  // Line breaks and tabs are always replaced by spaces.
  a_no_ctrl: assert property (@(posedge clk) disable iff (rst)
    folded_valid |-> folded.out_byte != ucuf_pkg::ASCII_CR &&
                     folded.out_byte != ucuf_pkg::ASCII_LF &&
                     folded.out_byte != ucuf_pkg::ASCII_TAB)
    else $error("control byte reached the output");

endmodule

bind utf8_cyrillic_upper_fold ucuf_checker u_ucuf_checker (.*);
